// ===== rtl/sha3_pkg.sv =====
// sha3_pkg: shared types, sizes and keccak-f[1600] constants
// used by sha3_round and sha3_256_hasher; no dependencies
package sha3_pkg;

    localparam int LANE_W           = 64;
    localparam int NUM_LANES        = 25;
    localparam int LANE_IDX_W       = 5;
    localparam int NUM_ROUNDS       = 24;
    localparam int ROUND_W          = 5;
    localparam int RATE_LANES_DEF   = 17;
    localparam int DIGEST_WORDS_DEF = 4;

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [NUM_LANES-1:0][LANE_W-1:0] state_t;

    // domain pad byte and final rate byte
    localparam logic [7:0] PAD_FIRST = 8'h06;
    localparam lane_t PAD_END = 64'h8000_0000_0000_0000;

    // rho rotation offset of lane x + 5*y
    localparam int RHO_OFS [NUM_LANES] = '{
         0,  1, 62, 28, 27,
        36, 44,  6, 55, 20,
         3, 10, 43, 25, 39,
        41, 45, 15, 21,  8,
        18,  2, 61, 56, 14
    };

    // left rotate by a constant amount
    function automatic lane_t rotl64(input lane_t v, input int n);
        lane_t r;
        if (n == 0)
        begin
            r = v;
        end
        else
        begin
            r = (v << n) | (v >> (LANE_W - n));
        end
        return r;
    endfunction

    // iota round constants
    function automatic lane_t round_const(input logic [ROUND_W-1:0] rnd);
        lane_t rc;
        case (rnd)
            5'd0:    rc = 64'h0000_0000_0000_0001;
            5'd1:    rc = 64'h0000_0000_0000_8082;
            5'd2:    rc = 64'h8000_0000_0000_808A;
            5'd3:    rc = 64'h8000_0000_8000_8000;
            5'd4:    rc = 64'h0000_0000_0000_808B;
            5'd5:    rc = 64'h0000_0000_8000_0001;
            5'd6:    rc = 64'h8000_0000_8000_8081;
            5'd7:    rc = 64'h8000_0000_0000_8009;
            5'd8:    rc = 64'h0000_0000_0000_008A;
            5'd9:    rc = 64'h0000_0000_0000_0088;
            5'd10:   rc = 64'h0000_0000_8000_8009;
            5'd11:   rc = 64'h0000_0000_8000_000A;
            5'd12:   rc = 64'h0000_0000_8000_808B;
            5'd13:   rc = 64'h8000_0000_0000_008B;
            5'd14:   rc = 64'h8000_0000_0000_8089;
            5'd15:   rc = 64'h8000_0000_0000_8003;
            5'd16:   rc = 64'h8000_0000_0000_8002;
            5'd17:   rc = 64'h8000_0000_0000_0080;
            5'd18:   rc = 64'h0000_0000_0000_800A;
            5'd19:   rc = 64'h8000_0000_8000_000A;
            5'd20:   rc = 64'h8000_0000_8000_8081;
            5'd21:   rc = 64'h8000_0000_0000_8080;
            5'd22:   rc = 64'h0000_0000_8000_0001;
            5'd23:   rc = 64'h8000_0000_8000_8008;
            default: rc = '0;
        endcase
        return rc;
    endfunction

endpackage

// ===== rtl/sha3_round.sv =====
// sha3_round: one keccak-f[1600] round (theta, rho, pi, chi, iota)
// shared by all 24 rounds; depends on sha3_pkg
module sha3_round (
    input  sha3_pkg::state_t                    state_in,
    input  logic [sha3_pkg::ROUND_W-1:0]        round_idx,
    output sha3_pkg::state_t                    state_out
);

    sha3_pkg::lane_t col_par [5];
    sha3_pkg::lane_t col_mix [5];
    sha3_pkg::lane_t pi_lane [sha3_pkg::NUM_LANES];
    sha3_pkg::lane_t chi_lane [sha3_pkg::NUM_LANES];

    // theta column parity
    for (genvar gx = 0; gx < 5; gx++)
    begin : g_par
        assign col_par[gx] = state_in[gx] ^ state_in[gx+5] ^ state_in[gx+10]
                           ^ state_in[gx+15] ^ state_in[gx+20];
    end

    // theta column mix
    for (genvar gx = 0; gx < 5; gx++)
    begin : g_mix
        localparam int XM1 = (gx + 4) % 5;
        localparam int XP1 = (gx + 1) % 5;
        assign col_mix[gx] = col_par[XM1] ^ sha3_pkg::rotl64(col_par[XP1], 1);
    end

    // theta apply, rho rotate, pi permute
    for (genvar gy = 0; gy < 5; gy++)
    begin : g_rp_y
        for (genvar gx = 0; gx < 5; gx++)
        begin : g_rp_x
            localparam int SRC = gx + 5 * gy;
            localparam int DST = gy + 5 * ((2 * gx + 3 * gy) % 5);
            localparam int ROT = sha3_pkg::RHO_OFS[SRC];
            assign pi_lane[DST] = sha3_pkg::rotl64(state_in[SRC] ^ col_mix[gx], ROT);
        end
    end

    // chi
    for (genvar gy = 0; gy < 5; gy++)
    begin : g_chi_y
        for (genvar gx = 0; gx < 5; gx++)
        begin : g_chi_x
            localparam int I0 = gx + 5 * gy;
            localparam int I1 = (gx + 1) % 5 + 5 * gy;
            localparam int I2 = (gx + 2) % 5 + 5 * gy;
            assign chi_lane[I0] = pi_lane[I0] ^ (~pi_lane[I1] & pi_lane[I2]);
        end
    end

    // iota on lane zero
    assign state_out[0] = chi_lane[0] ^ sha3_pkg::round_const(round_idx);
    for (genvar gi = 1; gi < sha3_pkg::NUM_LANES; gi++)
    begin : g_out
        assign state_out[gi] = chi_lane[gi];
    end

endmodule

// ===== rtl/sha3_256_hasher.sv =====
// sha3_256_hasher: sha3-256 sponge with one iterated keccak round unit
// depends on sha3_pkg and sha3_round
//
//  channel | direction | signals                                   | beat
//  input   | in        | in_valid in_ready lane_data byte_count     | one lane,
//          |           | message_end                               | 0..8 bytes
//  output  | out       | out_valid out_ready digest_word word_index | one digest
//          |           | digest_last                               | word
//
// a lane that does not close a block is absorbed in place; one that closes the rate
// starts a permutation, one round at a time through the single round unit.
// a short final lane adds a permutation; an eight byte final lane adds a pad step
// and a permutation, plus a permutation first when it fills its block exactly;
// then DIGEST_WORDS output beats are loaded, one per beat the receiver takes.
// reset clears the state, the lane position and out_valid at once, not the payload;
// in_ready is low during rounds, the pad state and digest loading.
module sha3_256_hasher #(
    parameter int RATE_LANES   = sha3_pkg::RATE_LANES_DEF,
    parameter int DIGEST_WORDS = sha3_pkg::DIGEST_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] lane_data,
    input  logic [3:0]  byte_count,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        digest_last
);

    localparam int POS_W = $clog2(RATE_LANES);
    localparam int CNT_W = $clog2(DIGEST_WORDS + 1) + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(RATE_LANES - 1);
    localparam logic [sha3_pkg::LANE_IDX_W-1:0] END_LANE =
        sha3_pkg::LANE_IDX_W'(RATE_LANES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGEST_WORDS - 1);
    localparam logic [sha3_pkg::ROUND_W-1:0] ROUND_LAST =
        sha3_pkg::ROUND_W'(sha3_pkg::NUM_ROUNDS - 1);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [sha3_pkg::ROUND_W-1:0] ROUND_ONE = sha3_pkg::ROUND_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PERM = 4'b0010,
        ST_PAD  = 4'b0100,
        ST_OUT  = 4'b1000
    } seq_state_t;

    seq_state_t                       seq_reg, seq_next;
    sha3_pkg::state_t                 lanes_reg, lanes_next;
    sha3_pkg::state_t                 round_out;
    logic [POS_W-1:0]                 pos_reg, pos_next;
    logic [sha3_pkg::ROUND_W-1:0]     rnd_reg, rnd_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             pad_pend_reg, pad_pend_next;
    logic                             fin_pend_reg, fin_pend_next;
    logic                             out_valid_reg, out_valid_next;
    logic [63:0]                      word_reg, word_next;
    logic [1:0]                       idx_reg, idx_next;
    logic                             last_reg, last_next;

    logic                             in_fire;
    logic                             out_load;
    logic [3:0]                       count_sat;
    sha3_pkg::lane_t                  data_masked;
    sha3_pkg::lane_t                  data_padded;
    sha3_pkg::lane_t                  xor_val;
    logic                             xor_en;
    logic                             end_en;
    logic [sha3_pkg::LANE_IDX_W-1:0]  pos_ext;

    // shared round unit
    sha3_round u_round (
        .state_in  (lanes_reg),
        .round_idx (rnd_reg),
        .state_out (round_out)
    );

    assign in_ready = (seq_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (seq_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign pos_ext  = sha3_pkg::LANE_IDX_W'(pos_reg);

    // byte masking and pad byte placement
    always_comb
    begin
        count_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
        for (int b = 0; b < 8; b++)
        begin
            data_masked[8*b +: 8] = (4'(b) < count_sat) ? lane_data[8*b +: 8] : 8'h00;
            data_padded[8*b +: 8] = (4'(b) == count_sat) ?
                                    sha3_pkg::PAD_FIRST : data_masked[8*b +: 8];
        end
    end

    // sequencer and state update
    always_comb
    begin
        seq_next       = seq_reg;
        pos_next       = pos_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        pad_pend_next  = pad_pend_reg;
        fin_pend_next  = fin_pend_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        xor_val        = '0;
        xor_en         = 1'b0;
        end_en         = 1'b0;
        lanes_next     = lanes_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    xor_en = 1'b1;
                    if (message_end && (count_sat != 4'd8))
                    begin
                        // short final lane: pad in place and finish
                        xor_val       = data_padded;
                        end_en        = 1'b1;
                        fin_pend_next = 1'b1;
                        pos_next      = '0;
                        seq_next      = ST_PERM;
                    end
                    else
                    begin
                        xor_val = data_masked;
                        if (pos_reg == POS_LAST)
                        begin
                            pos_next      = '0;
                            pad_pend_next = message_end;
                            seq_next      = ST_PERM;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_ONE;
                            if (message_end)
                            begin
                                seq_next = ST_PAD;
                            end
                        end
                    end
                end
            end
            ST_PAD:
            begin
                // padding in a lane of its own
                xor_en        = 1'b1;
                xor_val       = {56'h0, sha3_pkg::PAD_FIRST};
                end_en        = 1'b1;
                fin_pend_next = 1'b1;
                pos_next      = '0;
                seq_next      = ST_PERM;
            end
            ST_PERM:
            begin
                if (rnd_reg == ROUND_LAST)
                begin
                    rnd_next = '0;
                    if (pad_pend_reg)
                    begin
                        pad_pend_next = 1'b0;
                        seq_next      = ST_PAD;
                    end
                    else if (fin_pend_reg)
                    begin
                        fin_pend_next = 1'b0;
                        cnt_next      = '0;
                        seq_next      = ST_OUT;
                    end
                    else
                    begin
                        seq_next = ST_IDLE;
                    end
                end
                else
                begin
                    rnd_next = rnd_reg + ROUND_ONE;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    word_next      = lanes_reg[sha3_pkg::LANE_IDX_W'(cnt_reg)];
                    idx_next       = cnt_reg[1:0];
                    last_next      = (cnt_reg == CNT_LAST);
                    if (cnt_reg == CNT_LAST)
                    begin
                        seq_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_ONE;
                    end
                end
            end
            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase

        // lane xor, permutation round or clear
        if (seq_reg == ST_PERM)
        begin
            lanes_next = round_out;
        end
        else if (out_load && (cnt_reg == CNT_LAST))
        begin
            lanes_next = '0;
        end
        else
        begin
            for (int i = 0; i < sha3_pkg::NUM_LANES; i++)
            begin
                if (xor_en && (sha3_pkg::LANE_IDX_W'(i) == pos_ext))
                begin
                    lanes_next[i] = lanes_next[i] ^ xor_val;
                end
                if (end_en && (sha3_pkg::LANE_IDX_W'(i) == END_LANE))
                begin
                    lanes_next[i] = lanes_next[i] ^ sha3_pkg::PAD_END;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            lanes_reg     <= '0;
            pos_reg       <= '0;
            rnd_reg       <= '0;
            cnt_reg       <= '0;
            pad_pend_reg  <= 1'b0;
            fin_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            lanes_reg     <= lanes_next;
            pos_reg       <= pos_next;
            rnd_reg       <= rnd_next;
            cnt_reg       <= cnt_next;
            pad_pend_reg  <= pad_pend_next;
            fin_pend_reg  <= fin_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = word_reg;
    assign word_index  = idx_reg;
    assign digest_last = last_reg;

endmodule

// ===== verif/sha3_256_hasher_tb.sv =====
// sha3_256_hasher_tb: self-checking bench for the sha3-256 lane hasher
// depends on sha3_pkg and the sha3_256_hasher rtl; a class tracks the sponge
// and checks each digest word, plain tasks drive the lane channel
module sha3_256_hasher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RATE        = sha3_pkg::RATE_LANES_DEF;
    localparam int DIGEST      = sha3_pkg::DIGEST_WORDS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 64;
    localparam int HOLD_LONG   = 300;
    localparam int PHASE_ITEMS = 150;

    localparam logic [7:0] PAD_DOMAIN = 8'h06;
    localparam sha3_pkg::lane_t PAD_RATE_END = 64'h8000_0000_0000_0000;

    // iota constants, fips 202
    localparam sha3_pkg::lane_t IOTA_RC [24] = '{
        64'h0000_0000_0000_0001, 64'h0000_0000_0000_8082,
        64'h8000_0000_0000_808A, 64'h8000_0000_8000_8000,
        64'h0000_0000_0000_808B, 64'h0000_0000_8000_0001,
        64'h8000_0000_8000_8081, 64'h8000_0000_0000_8009,
        64'h0000_0000_0000_008A, 64'h0000_0000_0000_0088,
        64'h0000_0000_8000_8009, 64'h0000_0000_8000_000A,
        64'h0000_0000_8000_808B, 64'h8000_0000_0000_008B,
        64'h8000_0000_0000_8089, 64'h8000_0000_0000_8003,
        64'h8000_0000_0000_8002, 64'h8000_0000_0000_0080,
        64'h0000_0000_0000_800A, 64'h8000_0000_8000_000A,
        64'h8000_0000_8000_8081, 64'h8000_0000_0000_8080,
        64'h0000_0000_8000_0001, 64'h8000_0000_8000_8008
    };

    // rho offset of lane x + 5*y
    localparam int RHO_AMOUNT [25] = '{
         0,  1, 62, 28, 27,
        36, 44,  6, 55, 20,
         3, 10, 43, 25, 39,
        41, 45, 15, 21,  8,
        18,  2, 61, 56, 14
    };

    typedef struct {
        sha3_pkg::lane_t word;
        logic [1:0]      idx;
        logic            last;
    } digest_beat_t;

    // sponge predictor and digest word checker
    class sha3_digest_predictor;
        sha3_pkg::lane_t sponge [25];
        int unsigned     rate_pos;
        digest_beat_t    pending [$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            clear_sponge();
        endfunction

        function void clear_sponge();
            foreach (sponge[i])
            begin
                sponge[i] = '0;
            end
            rate_pos = 0;
        endfunction

        function sha3_pkg::lane_t rot_left(sha3_pkg::lane_t v, int unsigned n);
            if (n == 0)
            begin
                return v;
            end
            return (v << n) | (v >> (64 - n));
        endfunction

        // 24 rounds of keccak-f[1600] on the sponge
        function void permute_sponge();
            sha3_pkg::lane_t col [5];
            sha3_pkg::lane_t theta [5];
            sha3_pkg::lane_t mixed [25];
            for (int r = 0; r < 24; r++)
            begin
                for (int x = 0; x < 5; x++)
                begin
                    col[x] = sponge[x] ^ sponge[x + 5] ^ sponge[x + 10]
                           ^ sponge[x + 15] ^ sponge[x + 20];
                end
                for (int x = 0; x < 5; x++)
                begin
                    theta[x] = col[(x + 4) % 5] ^ rot_left(col[(x + 1) % 5], 1);
                end
                for (int i = 0; i < 25; i++)
                begin
                    sponge[i] ^= theta[i % 5];
                end
                for (int y = 0; y < 5; y++)
                begin
                    for (int x = 0; x < 5; x++)
                    begin
                        mixed[y + 5 * ((2 * x + 3 * y) % 5)] =
                            rot_left(sponge[x + 5 * y], RHO_AMOUNT[x + 5 * y]);
                    end
                end
                for (int y = 0; y < 5; y++)
                begin
                    for (int x = 0; x < 5; x++)
                    begin
                        sponge[x + 5 * y] = mixed[x + 5 * y]
                            ^ (~mixed[(x + 1) % 5 + 5 * y] & mixed[(x + 2) % 5 + 5 * y]);
                    end
                end
                sponge[0] ^= IOTA_RC[r];
            end
        endfunction

        // xor one full lane into the rate, permute when the block is full
        function void absorb_lane(sha3_pkg::lane_t lane);
            if (rate_pos >= RATE)
            begin
                rate_pos = 0;
            end
            sponge[rate_pos] ^= lane;
            rate_pos++;
            if (rate_pos >= RATE)
            begin
                permute_sponge();
                rate_pos = 0;
            end
        endfunction

        // note an accepted input beat, queue the digest on message end
        function void absorb_beat(sha3_pkg::lane_t data, logic [3:0] count, logic last_in);
            sha3_pkg::lane_t lane;
            int unsigned     nbytes;
            digest_beat_t    w;
            nbytes = (count > 4'd8) ? 8 : count;
            lane = data;
            if (nbytes < 8)
            begin
                lane = data & ((64'd1 << (8 * nbytes)) - 64'd1);
            end
            if (!last_in)
            begin
                absorb_lane(lane);
                return;
            end
            // a full final lane is absorbed first, padding goes to the next lane or a fresh block
            if (nbytes == 8)
            begin
                absorb_lane(lane);
                lane = '0;
                nbytes = 0;
            end
            if (rate_pos >= RATE)
            begin
                rate_pos = 0;
            end
            sponge[rate_pos] ^= lane ^ (64'(PAD_DOMAIN) << (8 * nbytes));
            sponge[RATE - 1] ^= PAD_RATE_END;
            permute_sponge();
            for (int k = 0; k < DIGEST; k++)
            begin
                w.word = sponge[k];
                w.idx  = 2'(k);
                w.last = (k == DIGEST - 1);
                pending = {pending, w};
            end
            clear_sponge();
        endfunction

        // compare one accepted digest beat with the oldest expected word
        function void check_word(sha3_pkg::lane_t word, logic [1:0] idx, logic last_out);
            digest_beat_t w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected digest beat: got word %h index %0d last %0b",
                         $time, word, idx, last_out);
                mismatches++;
                return;
            end
            w = pending.pop_front();
            if (word !== w.word)
            begin
                $display("%0t: digest_word mismatch: expected %h, actual %h",
                         $time, w.word, word);
                mismatches++;
            end
            if (idx !== w.idx)
            begin
                $display("%0t: word_index mismatch: expected %0d, actual %0d",
                         $time, w.idx, idx);
                mismatches++;
            end
            if (last_out !== w.last)
            begin
                $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                         $time, w.last, last_out);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] lane_data = '0;
    logic [3:0]  byte_count = '0;
    logic        message_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned ready_hold_left = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    sha3_digest_predictor pred = new();

    sha3_256_hasher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lane_data   (lane_data),
        .byte_count  (byte_count),
        .message_end (message_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("** sha3_256_hasher: FAILED **");
            $finish;
        end
    end

    // digest side: check accepted beats, random stalls and long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            pred.check_word(digest_word, word_index, digest_last);
        end
        if (ready_hold_left > 0)
        begin
            ready_hold_left = ready_hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offer one lane beat, hold it until accepted
    task automatic send_lane(input logic [63:0] data, input logic [3:0] count,
                             input logic last_in);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        lane_data   <= data;
        byte_count  <= count;
        message_end <= last_in;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pred.absorb_beat(data, count, last_in);
        items_sent++;
    endtask

    function automatic logic [63:0] rand_lane();
        return {$urandom(), $urandom()};
    endfunction

    // one message: body lanes, mostly full with a few short ones, then the final lane
    task automatic send_message(input int unsigned body_lanes, input logic [3:0] last_count);
        logic [3:0] count;
        for (int unsigned i = 0; i < body_lanes; i++)
        begin
            count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_lane(rand_lane(), count, 1'b0);
        end
        send_lane(rand_lane(), last_count, 1'b1);
    endtask

    // random message shapes, biased toward block boundaries
    task automatic send_random_message();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: send_message($urandom_range(0, 1) ? 16 : 33, 4'd8);
            1: send_message($urandom_range(0, 1) ? 17 : 34, 4'($urandom_range(0, 15)));
            default: send_message($urandom_range(0, 12), 4'($urandom_range(0, 15)));
        endcase
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 49;

        // empty message, garbage above the valid bytes
        send_lane('1, 4'd0, 1'b1);
        // zero lane then all-ones final with count above eight
        send_lane('0, 4'd8, 1'b0);
        send_lane('1, 4'd15, 1'b1);
        // short and oversized non-final lanes, one byte final
        send_lane(rand_lane(), 4'd3, 1'b0);
        send_lane(rand_lane(), 4'd9, 1'b0);
        send_lane(rand_lane(), 4'd1, 1'b1);
        // seven byte single lane message
        send_lane(rand_lane(), 4'd7, 1'b1);
        // message filling its block exactly
        send_message(16, 4'd8);

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // long receiver hold-off while lanes keep coming
                    ready_hold_left = HOLD_LONG;
                end
            endcase
            while (items_sent < 24 + (phase + 1) * PHASE_ITEMS)
            begin
                send_random_message();
            end
        end
        in_valid <= 1'b0;

        // drain the digest side
        while (pred.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pred.mismatches == 0 && pred.pending.size() == 0)
        begin
            $display("** sha3_256_hasher: PASSED **");
        end
        else
        begin
            $display("** sha3_256_hasher: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sha3_pkg.sv
rtl/sha3_round.sv
rtl/sha3_256_hasher.sv
verif/sha3_256_hasher_tb.sv
